@@ rtl/windowed_model_weight_gen_assert.svh @@
`ifndef WINDOWED_MODEL_WEIGHT_GEN_ASSERT_SVH
`define WINDOWED_MODEL_WEIGHT_GEN_ASSERT_SVH

// same-cycle implication, held off during reset
`define WMWG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define WMWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define WMWG_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wmwg_pkg.sv @@
package wmwg_pkg;

  localparam int MODE_W     = 2;
  localparam int SIGMA_W    = 16;
  localparam int ROOF_W     = 44;
  localparam int EXT_W      = 11;
  localparam int POS_W      = 10;
  localparam int WEIGHT_W   = 44;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 44;

  // window sums at or above 2^SUM_BITS always saturate to the roof
  localparam int SUM_BITS  = 22;
  localparam int NEAR_ROWS = 5;

  localparam logic [ROOF_W-1:0] ROOF_RESET = {ROOF_W{1'b1}};
  localparam logic [EXT_W-1:0]  EXT_RESET  = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_ONES   = 2'd0,
    MODE_FLOOR  = 2'd1,
    MODE_ENERGY = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_SIGMA = 3'd1,
    REG_ROOF  = 3'd2,
    REG_ROWS  = 3'd3,
    REG_COLS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic energy;
    logic force_roof;
    logic frame_end;
  } stage_ctl_t;

endpackage

@@ rtl/wmwg_ram.sv @@
module wmwg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wmwg_lines.sv @@
module wmwg_lines import wmwg_pkg::*; #(
  parameter int MAX_COLS        = 1024,
  parameter int MAX_ROWS        = 1024,
  parameter int TIME_HALF_WIN   = 5,
  parameter int OFFSET_HALF_WIN = 3,
  parameter int SAMPLE_BITS     = 16,
  localparam int RW         = $clog2(MAX_ROWS),
  localparam int CW         = $clog2(MAX_COLS),
  localparam int RXW        = $clog2(MAX_ROWS + 1),
  localparam int CXW        = $clog2(MAX_COLS + 1),
  localparam int MAG_LINES  = 2 * OFFSET_HALF_WIN - 1,
  localparam int FLAG_LINES = OFFSET_HALF_WIN
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_data_zero,
  input  logic [RXW-1:0]                        rows_ext,
  input  logic [CXW-1:0]                        cols_ext,
  output logic                                  vb,
  output logic [SAMPLE_BITS-1:0]                mag_b,
  output logic [RW-1:0]                         row_b,
  output logic [CW-1:0]                         col_b,
  output logic                                  zero_b,
  output logic [MAG_LINES-1:0][SAMPLE_BITS-1:0] line_mag
);

  localparam int MPW = (MAG_LINES > 1) ? $clog2(MAG_LINES) : 1;
  localparam int FPW = (FLAG_LINES > 1) ? $clog2(FLAG_LINES) : 1;

  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [MPW-1:0] mptr_r, mptr_nxt;
  logic [FPW-1:0] fptr_r, fptr_nxt;
  logic [CXW:0]   col_inc;
  logic [RXW:0]   row_inc;
  logic           acc;

  logic [SAMPLE_BITS-1:0] raw, mag;

  logic                   va_r;
  logic [SAMPLE_BITS-1:0] mag_a_r;
  logic                   dz_a_r;
  logic [RW-1:0]          row_a_r;
  logic [CW-1:0]          col_a_r;
  logic [MPW-1:0]         mptr_a_r;
  logic [FPW-1:0]         fptr_a_r;

  logic [FPW-1:0] fsel_a;
  logic [CW-1:0]  ft_a;
  logic           byp_a;
  logic           rd_en;

  logic                   vb_r;
  logic [SAMPLE_BITS-1:0] mag_b_r;
  logic [RW-1:0]          row_b_r;
  logic [CW-1:0]          col_b_r;
  logic [FPW-1:0]         fsel_b_r;
  logic                   byp_b_r;
  logic                   dz_b_r;
  logic [FLAG_LINES-1:0]  flag_rd;

  assign acc = in_valid && adv;
  assign raw = in_sample;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

  // raster position
  assign col_inc = (CXW + 1)'(col_r) + (CXW + 1)'(1);
  assign row_inc = (RXW + 1)'(row_r) + (RXW + 1)'(1);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    mptr_nxt = mptr_r;
    fptr_nxt = fptr_r;
    if (acc) begin
      if (col_inc >= (CXW + 1)'(cols_ext)) begin
        col_nxt = '0;
        if (row_inc >= (RXW + 1)'(rows_ext)) begin
          row_nxt  = '0;
          mptr_nxt = '0;
          fptr_nxt = '0;
        end else begin
          row_nxt  = RW'(row_inc);
          mptr_nxt = (mptr_r == MPW'(MAG_LINES - 1)) ? '0 : mptr_r + MPW'(1);
          fptr_nxt = (fptr_r == FPW'(FLAG_LINES - 1)) ? '0 : fptr_r + FPW'(1);
        end
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      mptr_r <= '0;
      fptr_r <= '0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      mptr_r <= mptr_nxt;
      fptr_r <= fptr_nxt;
      if (adv) begin
        va_r <= in_valid;
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mag_a_r  <= mag;
      dz_a_r   <= in_data_zero;
      row_a_r  <= row_r;
      col_a_r  <= col_r;
      mptr_a_r <= mptr_r;
      fptr_a_r <= fptr_r;
    end
    if (rd_en) begin
      mag_b_r  <= mag_a_r;
      row_b_r  <= row_a_r;
      col_b_r  <= col_a_r;
      fsel_b_r <= fsel_a;
      byp_b_r  <= byp_a;
      dz_b_r   <= dz_a_r;
    end
  end

  // line stores: read all lines (flags at ft_a), overwrite oldest
  assign rd_en  = va_r && adv;
  assign fsel_a = (fptr_a_r == FPW'(FLAG_LINES - 1)) ? '0 : fptr_a_r + FPW'(1);
  assign ft_a   = col_a_r - CW'(TIME_HALF_WIN - 1);
  assign byp_a  = (fsel_a == fptr_a_r) && (ft_a == col_a_r);

  for (genvar i = 0; i < MAG_LINES; i++) begin : g_mag
    wmwg_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_COLS)
    ) u_mag_ram (
      .clk  (clk),
      .we   (rd_en && (mptr_a_r == MPW'(i))),
      .waddr(col_a_r),
      .wdata(mag_a_r),
      .re   (rd_en),
      .raddr(col_a_r),
      .rdata(line_mag[i])
    );
  end

  for (genvar i = 0; i < FLAG_LINES; i++) begin : g_flag
    wmwg_ram #(
      .WIDTH(1),
      .DEPTH(MAX_COLS)
    ) u_flag_ram (
      .clk  (clk),
      .we   (rd_en && (fptr_a_r == FPW'(i))),
      .waddr(col_a_r),
      .wdata(dz_a_r),
      .re   (rd_en),
      .raddr(ft_a),
      .rdata(flag_rd[i])
    );
  end

  assign vb     = vb_r;
  assign mag_b  = mag_b_r;
  assign row_b  = row_b_r;
  assign col_b  = col_b_r;
  assign zero_b = byp_b_r ? dz_b_r : flag_rd[fsel_b_r];

endmodule

@@ rtl/wmwg_window.sv @@
module wmwg_window import wmwg_pkg::*; #(
  parameter int MAX_COLS        = 1024,
  parameter int MAX_ROWS        = 1024,
  parameter int TIME_HALF_WIN   = 5,
  parameter int OFFSET_HALF_WIN = 3,
  parameter int SAMPLE_BITS     = 16,
  localparam int RW        = $clog2(MAX_ROWS),
  localparam int CW        = $clog2(MAX_COLS),
  localparam int RXW       = $clog2(MAX_ROWS + 1),
  localparam int CXW       = $clog2(MAX_COLS + 1),
  localparam int MAG_LINES = 2 * OFFSET_HALF_WIN - 1,
  localparam int WIN_COLS  = 2 * TIME_HALF_WIN,
  localparam int CSW = $clog2(64'(2 * OFFSET_HALF_WIN) * (64'(1) << (SAMPLE_BITS - 1)) + 64'(1)),
  localparam int WSW = $clog2(64'(WIN_COLS) * 64'(2 * OFFSET_HALF_WIN) *
                              (64'(1) << (SAMPLE_BITS - 1)) + 64'(1)),
  localparam int SWW = (SAMPLE_BITS > SIGMA_W) ? SAMPLE_BITS : SIGMA_W
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  vb,
  input  logic [SAMPLE_BITS-1:0]                mag_b,
  input  logic [RW-1:0]                         row_b,
  input  logic [CW-1:0]                         col_b,
  input  logic                                  zero_b,
  input  logic [MAG_LINES-1:0][SAMPLE_BITS-1:0] line_mag,
  input  mode_t                                 mode,
  input  logic [SIGMA_W-1:0]                    sigma,
  input  logic [RXW-1:0]                        rows_ext,
  input  logic [CXW-1:0]                        cols_ext,
  output stage_ctl_t                            ctl_c,
  output logic [SWW-1:0]                        simple_w_c,
  output logic [POS_W-1:0]                      row_c,
  output logic [POS_W-1:0]                      col_c,
  output logic [WSW-1:0]                        wsum
);

  localparam int RQ = RXW + 2;
  localparam int CQ = CXW + 2;

  logic [CSW-1:0] csum;
  logic [CSW-1:0] colsum_r [WIN_COLS];
  logic [WSW-1:0] wsum_r;
  logic [WSW-1:0] tail;

  logic [RQ-1:0] rq, rows_q, ih, half;
  logic [CQ-1:0] cq, cols_q, it;
  logic          row_in, col_in, near;
  logic          end_pix, end_win;

  stage_ctl_t           ctl_nxt, ctl_c_r;
  logic [SWW-1:0]       simple_w_nxt, simple_w_c_r;
  logic [POS_W-1:0]     row_nxt, col_nxt, row_c_r, col_c_r;

  always_comb begin
    csum = CSW'(mag_b);
    for (int k = 0; k < MAG_LINES; k++) begin
      csum = csum + CSW'(line_mag[k]);
    end
  end

  // column sums that stay in the window after the shift
  always_comb begin
    tail = '0;
    for (int k = 0; k < WIN_COLS - 1; k++) begin
      tail = tail + WSW'(colsum_r[k]);
    end
  end

  // window sum over the column sum shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      for (int k = 0; k < WIN_COLS; k++) begin
        colsum_r[k] <= '0;
      end
    end else if (adv && vb) begin
      wsum_r      <= WSW'(csum) + tail;
      colsum_r[0] <= csum;
      for (int k = 1; k < WIN_COLS; k++) begin
        colsum_r[k] <= colsum_r[k-1];
      end
    end
  end

  // window center trails the sample by OFFSET_HALF_WIN-1 rows and TIME_HALF_WIN-1 cols
  assign rq     = RQ'(row_b);
  assign cq     = CQ'(col_b);
  assign rows_q = RQ'(rows_ext);
  assign cols_q = CQ'(cols_ext);
  assign ih     = rq - RQ'(OFFSET_HALF_WIN - 1);
  assign it     = cq - CQ'(TIME_HALF_WIN - 1);
  assign half   = rows_q >> 1;
  assign row_in = (rq >= RQ'(2 * OFFSET_HALF_WIN - 1)) && (rq + RQ'(1) < rows_q);
  assign col_in = (cq >= CQ'(2 * TIME_HALF_WIN - 1)) && (cq + CQ'(1) < cols_q);
  assign near   = (ih + RQ'(NEAR_ROWS) > half) && (ih < half + RQ'(NEAR_ROWS));
  assign end_pix = (rq + RQ'(1) == rows_q) && (cq + CQ'(1) == cols_q);
  assign end_win = (rq + RQ'(2) == rows_q) && (cq + CQ'(2) == cols_q);

  always_comb begin
    ctl_nxt            = '0;
    ctl_nxt.valid      = vb;
    ctl_nxt.force_roof = zero_b && near;
    simple_w_nxt       = SWW'(1);
    row_nxt            = POS_W'(row_b);
    col_nxt            = POS_W'(col_b);
    unique case (mode)
      MODE_ONES: begin
        ctl_nxt.emit      = 1'b1;
        ctl_nxt.frame_end = end_pix;
      end
      MODE_FLOOR: begin
        ctl_nxt.emit      = 1'b1;
        ctl_nxt.frame_end = end_pix;
        simple_w_nxt      = (SWW'(mag_b) > SWW'(sigma)) ? SWW'(mag_b) : SWW'(sigma);
      end
      MODE_ENERGY: begin
        ctl_nxt.emit      = row_in && col_in;
        ctl_nxt.energy    = 1'b1;
        ctl_nxt.frame_end = end_win;
        row_nxt           = POS_W'(ih);
        col_nxt           = POS_W'(it);
      end
      default: ctl_nxt.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else if (adv) begin
      ctl_c_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vb) begin
      simple_w_c_r <= simple_w_nxt;
      row_c_r      <= row_nxt;
      col_c_r      <= col_nxt;
    end
  end

  assign ctl_c      = ctl_c_r;
  assign simple_w_c = simple_w_c_r;
  assign row_c      = row_c_r;
  assign col_c      = col_c_r;
  assign wsum       = wsum_r;

endmodule

@@ rtl/wmwg_weight.sv @@
module wmwg_weight import wmwg_pkg::*; #(
  parameter int WSUM_W   = 21,
  parameter int SIMPLE_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  stage_ctl_t          ctl_c,
  input  logic [SIMPLE_W-1:0] simple_w_c,
  input  logic [POS_W-1:0]    row_c,
  input  logic [POS_W-1:0]    col_c,
  input  logic [WSUM_W-1:0]   wsum,
  input  logic [SIGMA_W-1:0]  sigma,
  input  logic [ROOF_W-1:0]   roof,
  output logic                out_valid,
  output logic [WEIGHT_W-1:0] out_weight,
  output logic [POS_W-1:0]    out_row,
  output logic [POS_W-1:0]    out_col,
  output logic                out_frame_end
);

  localparam int XW  = WSUM_W + SUM_BITS;
  localparam int SQW = 2 * SUM_BITS;
  localparam int S2W = 2 * SIGMA_W;
  localparam int EW  = ((SQW > S2W) ? SQW : S2W) + 1;

  logic [XW-1:0]       wsum_x;
  logic [SUM_BITS-1:0] lo;
  logic                ovf;
  logic [SQW-1:0]      sq;
  logic [S2W-1:0]      s2;

  stage_ctl_t          ctl_d_r;
  logic [SIMPLE_W-1:0] simple_w_d_r;
  logic [POS_W-1:0]    row_d_r, col_d_r;
  logic [SQW-1:0]      sq_d_r;
  logic [S2W-1:0]      s2_d_r;
  logic                ovf_d_r;

  logic [EW-1:0]       energy;
  logic [WEIGHT_W-1:0] weight_nxt;

  logic                out_valid_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [POS_W-1:0]    row_r, col_r;
  logic                frame_end_r;

  assign wsum_x = XW'(wsum);
  assign ovf    = |wsum_x[XW-1:SUM_BITS];
  assign lo     = wsum_x[SUM_BITS-1:0];
  assign sq     = lo * lo;
  assign s2     = sigma * sigma;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_d_r     <= ctl_c;
      out_valid_r <= ctl_d_r.valid && ctl_d_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_c.valid) begin
      simple_w_d_r <= simple_w_c;
      row_d_r      <= row_c;
      col_d_r      <= col_c;
      sq_d_r       <= sq;
      s2_d_r       <= s2;
      ovf_d_r      <= ovf;
    end
  end

  assign energy = EW'(s2_d_r) + EW'(sq_d_r);

  always_comb begin
    if (ctl_d_r.energy) begin
      if (ovf_d_r || ctl_d_r.force_roof) begin
        weight_nxt = roof;
      end else if (energy < EW'(roof)) begin
        weight_nxt = WEIGHT_W'(energy);
      end else begin
        weight_nxt = roof;
      end
    end else begin
      weight_nxt = WEIGHT_W'(simple_w_d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_d_r.valid) begin
      weight_r    <= weight_nxt;
      row_r       <= row_d_r;
      col_r       <= col_d_r;
      frame_end_r <= ctl_d_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_weight    = weight_r;
  assign out_row       = row_r;
  assign out_col       = col_r;
  assign out_frame_end = frame_end_r;

endmodule

@@ rtl/windowed_model_weight_gen.sv @@
// Model weight generator for raster-ordered model samples (row = offset, column = time).
// One sample is accepted every clock unless in_stall is high; its result, if any, passes
// the input stage, line store read, window sum, multiply and result registers. The line
// stores, 2*OFFSET_HALF_WIN-1 magnitude and OFFSET_HALF_WIN zero-flag RAMs of MAX_COLS
// entries, are all read once per sample, and one of each kind is written. The stores need
// no clearing after reset; the first rows of a frame never produce a windowed result.
// out_stall holds the whole pipeline while out_valid is high and is returned on in_stall
// in the same cycle. Configuration must be written only while idle; this is not enforced.
module windowed_model_weight_gen import wmwg_pkg::*; #(
  parameter int MAX_COLS        = 1024,
  parameter int MAX_ROWS        = 1024,
  parameter int TIME_HALF_WIN   = 5,
  parameter int OFFSET_HALF_WIN = 3,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_data_zero,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [WEIGHT_W-1:0]           out_weight,
  output logic [POS_W-1:0]              out_row,
  output logic [POS_W-1:0]              out_col,
  output logic                          out_frame_end,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = $clog2(MAX_COLS);
  localparam int RXW       = $clog2(MAX_ROWS + 1);
  localparam int CXW       = $clog2(MAX_COLS + 1);
  localparam int RCMP      = (RXW > EXT_W) ? RXW : EXT_W;
  localparam int CCMP      = (CXW > EXT_W) ? CXW : EXT_W;
  localparam int MAG_LINES = 2 * OFFSET_HALF_WIN - 1;
  localparam int WSW = $clog2(64'(2 * TIME_HALF_WIN) * 64'(2 * OFFSET_HALF_WIN) *
                              (64'(1) << (SAMPLE_BITS - 1)) + 64'(1));
  localparam int SWW = (SAMPLE_BITS > SIGMA_W) ? SAMPLE_BITS : SIGMA_W;

  mode_t              mode_r;
  logic [SIGMA_W-1:0] sigma_r;
  logic [ROOF_W-1:0]  roof_r;
  logic [EXT_W-1:0]   rows_used_r, cols_used_r;
  logic [RXW-1:0]     rows_ext;
  logic [CXW-1:0]     cols_ext;
  logic               adv;

  logic                                  vb;
  logic [SAMPLE_BITS-1:0]                mag_b;
  logic [RW-1:0]                         row_b;
  logic [CW-1:0]                         col_b;
  logic                                  zero_b;
  logic [MAG_LINES-1:0][SAMPLE_BITS-1:0] line_mag;

  stage_ctl_t       ctl_c;
  logic [SWW-1:0]   simple_w_c;
  logic [POS_W-1:0] row_c, col_c;
  logic [WSW-1:0]   wsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ONES;
      sigma_r     <= '0;
      roof_r      <= ROOF_RESET;
      rows_used_r <= EXT_RESET;
      cols_used_r <= EXT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r      <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_SIGMA: sigma_r     <= cfg_data[SIGMA_W-1:0];
        REG_ROOF:  roof_r      <= cfg_data[ROOF_W-1:0];
        REG_ROWS:  rows_used_r <= cfg_data[EXT_W-1:0];
        REG_COLS:  cols_used_r <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the store size as the store size
  assign rows_ext = (rows_used_r == '0) ? RXW'(1) :
                    (RCMP'(rows_used_r) > RCMP'(MAX_ROWS)) ? RXW'(MAX_ROWS) : RXW'(rows_used_r);
  assign cols_ext = (cols_used_r == '0) ? CXW'(1) :
                    (CCMP'(cols_used_r) > CCMP'(MAX_COLS)) ? CXW'(MAX_COLS) : CXW'(cols_used_r);

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  wmwg_lines #(
    .MAX_COLS       (MAX_COLS),
    .MAX_ROWS       (MAX_ROWS),
    .TIME_HALF_WIN  (TIME_HALF_WIN),
    .OFFSET_HALF_WIN(OFFSET_HALF_WIN),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_lines (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_sample   (in_sample),
    .in_data_zero(in_data_zero),
    .rows_ext    (rows_ext),
    .cols_ext    (cols_ext),
    .vb          (vb),
    .mag_b       (mag_b),
    .row_b       (row_b),
    .col_b       (col_b),
    .zero_b      (zero_b),
    .line_mag    (line_mag)
  );

  wmwg_window #(
    .MAX_COLS       (MAX_COLS),
    .MAX_ROWS       (MAX_ROWS),
    .TIME_HALF_WIN  (TIME_HALF_WIN),
    .OFFSET_HALF_WIN(OFFSET_HALF_WIN),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vb        (vb),
    .mag_b     (mag_b),
    .row_b     (row_b),
    .col_b     (col_b),
    .zero_b    (zero_b),
    .line_mag  (line_mag),
    .mode      (mode_r),
    .sigma     (sigma_r),
    .rows_ext  (rows_ext),
    .cols_ext  (cols_ext),
    .ctl_c     (ctl_c),
    .simple_w_c(simple_w_c),
    .row_c     (row_c),
    .col_c     (col_c),
    .wsum      (wsum)
  );

  wmwg_weight #(
    .WSUM_W  (WSW),
    .SIMPLE_W(SWW)
  ) u_weight (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl_c        (ctl_c),
    .simple_w_c   (simple_w_c),
    .row_c        (row_c),
    .col_c        (col_c),
    .wsum         (wsum),
    .sigma        (sigma_r),
    .roof         (roof_r),
    .out_valid    (out_valid),
    .out_weight   (out_weight),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_frame_end(out_frame_end)
  );

endmodule

@@ rtl/wmwg_chk.sv @@
`include "windowed_model_weight_gen_assert.svh"

module wmwg_chk import wmwg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [WEIGHT_W-1:0] out_weight,
  input logic [POS_W-1:0]    out_row,
  input logic [POS_W-1:0]    out_col,
  input logic                out_frame_end
);

  // no result beat leaves reset
  `WMWG_ASSERT_NEXT_RST(a_reset_idle, !rst_n, !out_valid, "result valid right after reset")

  // input is held back only by a result beat that is itself held
  `WMWG_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

  `WMWG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result beat dropped")

  `WMWG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_weight) && $stable(out_row) && $stable(out_col) && $stable(out_frame_end), "stalled result beat changed")

endmodule

bind windowed_model_weight_gen wmwg_chk u_chk (.*);

@@ tb/windowed_model_weight_gen_tb.sv @@
`timescale 1ns / 1ps

module windowed_model_weight_gen_tb;
  import wmwg_pkg::*;

  localparam int LINE_LEN    = 1024;
  localparam int MAX_EXT     = 1024;
  localparam int T_HALF      = 5;
  localparam int O_HALF      = 3;
  localparam int MAG_ROWS    = 2 * O_HALF - 1;
  localparam int FLAG_ROWS   = O_HALF;
  localparam int WIN_COLS    = 2 * T_HALF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic signed [15:0] sample;
    logic               data_zero;
  } sample_beat_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                frame_end;
  } weight_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_sample = '0;
  logic                  in_data_zero = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WEIGHT_W-1:0]   out_weight;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_col;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_model_weight_gen dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_data_zero  (in_data_zero),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_weight    (out_weight),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // weight predictor state
  bit [15:0]   mag_lines [MAG_ROWS][LINE_LEN];
  bit          zero_lines [FLAG_ROWS][LINE_LEN];
  int unsigned col_sums [WIN_COLS];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  mode_t       cur_mode = MODE_ONES;
  logic [15:0] cur_sigma = '0;
  logic [43:0] cur_roof = ROOF_RESET;
  logic [10:0] cur_rows = EXT_RESET;
  logic [10:0] cur_cols = EXT_RESET;

  sample_beat_t pending_samples[$];
  weight_beat_t expected_weights[$];
  sample_beat_t next_beat;
  weight_beat_t head;
  int unsigned  samples_queued = 0;
  int unsigned  samples_taken = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           zero_pct = 50;
  int           mismatches = 0;

  function automatic int unsigned frame_extent(logic [10:0] v);
    if (v == 11'd0) return 1;
    return (v > 11'(MAX_EXT)) ? MAX_EXT : int'(v);
  endfunction

  function automatic void predict_weight(logic signed [15:0] s, logic dz);
    int unsigned rows, cols, r, c, ci, ih, it, half, row_gap, mag, csum;
    int v;
    longint unsigned wsum, energy;
    logic [43:0] w;
    weight_beat_t b;
    rows = frame_extent(cur_rows);
    cols = frame_extent(cur_cols);
    r = row_pos;
    c = col_pos;
    ci = c % LINE_LEN;
    v = s;
    mag = (v < 0) ? -v : v;

    csum = mag;
    for (int k = 0; k < MAG_ROWS; k++) csum += mag_lines[k][ci];
    mag_lines[r % MAG_ROWS][ci] = mag[15:0];
    zero_lines[r % FLAG_ROWS][ci] = dz;
    for (int k = WIN_COLS - 1; k > 0; k--) col_sums[k] = col_sums[k-1];
    col_sums[0] = csum;
    wsum = 0;
    for (int k = 0; k < WIN_COLS; k++) wsum += col_sums[k];

    b.row = r[POS_W-1:0];
    b.col = c[POS_W-1:0];
    b.frame_end = (r == rows - 1) && (c == cols - 1);
    case (cur_mode)
      MODE_ONES: begin
        b.weight = 1;
        expected_weights.push_back(b);
      end
      MODE_FLOOR: begin
        b.weight = (mag > cur_sigma) ? WEIGHT_W'(mag) : WEIGHT_W'(cur_sigma);
        expected_weights.push_back(b);
      end
      MODE_ENERGY: begin
        if (r >= O_HALF - 1 && c >= T_HALF - 1) begin
          ih = r - (O_HALF - 1);
          it = c - (T_HALF - 1);
          if (ih >= O_HALF && ih + O_HALF < rows && it >= T_HALF && it + T_HALF < cols) begin
            half = rows / 2;
            row_gap = (ih > half) ? ih - half : half - ih;
            if (wsum >= (64'd1 << SUM_BITS)) begin
              w = cur_roof;
            end else begin
              energy = 64'(cur_sigma) * 64'(cur_sigma) + wsum * wsum;
              w = (energy < 64'(cur_roof)) ? energy[43:0] : cur_roof;
            end
            // near offset gap
            if (zero_lines[ih % FLAG_ROWS][it % LINE_LEN] && row_gap < NEAR_ROWS) w = cur_roof;
            b.weight = w;
            b.row = ih[POS_W-1:0];
            b.col = it[POS_W-1:0];
            b.frame_end = (ih == rows - O_HALF - 1) && (it == cols - T_HALF - 1);
            expected_weights.push_back(b);
          end
        end
      end
      default: ;
    endcase

    col_pos = c + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_weight(in_sample, in_data_zero);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_beat = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_sample <= next_beat.sample;
          in_data_zero <= next_beat.data_zero;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // weight monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_weights.size() == 0) begin
        $error("unexpected weight beat: row %0d col %0d weight %0d", out_row, out_col,
               out_weight);
        mismatches++;
      end else begin
        head = expected_weights.pop_front();
        if (out_weight !== head.weight) begin
          $error("weight: expected %0d, got %0d", head.weight, out_weight);
          mismatches++;
        end
        if (out_row !== head.row) begin
          $error("row: expected %0d, got %0d", head.row, out_row);
          mismatches++;
        end
        if (out_col !== head.col) begin
          $error("col: expected %0d, got %0d", head.col, out_col);
          mismatches++;
        end
        if (out_frame_end !== head.frame_end) begin
          $error("frame_end: expected %0d, got %0d", head.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("windowed_model_weight_gen_tb: FAIL");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [43:0] val);
    logic [43:0] keep, junk;
    case (idx)
      REG_MODE:  keep = 44'h3;
      REG_SIGMA: keep = 44'hffff;
      REG_ROOF:  keep = '1;
      default:   keep = 44'h7ff;
    endcase
    junk = 44'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 0) junk = '0;
    case (idx)
      REG_MODE:  cur_mode = mode_t'(val[1:0]);
      REG_SIGMA: cur_sigma = val[15:0];
      REG_ROOF:  cur_roof = val;
      REG_ROWS:  cur_rows = val[10:0];
      default:   cur_cols = val[10:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (val & keep) | (junk & ~keep);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(mode_t m, logic [43:0] sigma, logic [43:0] roof,
                           logic [43:0] rows, logic [43:0] cols);
    write_reg(REG_MODE, 44'(m));
    write_reg(REG_SIGMA, sigma);
    write_reg(REG_ROOF, roof);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  task automatic set_idling(int phase_no);
    case (phase_no % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 63; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 63; end
      default: begin gap_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // wait for every beat to land, then let the pipeline empty
  task automatic settle();
    while (samples_taken != samples_queued) @(posedge clk);
    while (expected_weights.size() != 0) @(posedge clk);
    gap_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] s, logic dz);
    sample_beat_t b;
    b.sample = s;
    b.data_zero = dz;
    pending_samples.push_back(b);
    samples_queued++;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd0;
          default: return 16'sd1;
        endcase
      end
      1, 2: return 16'(int'($urandom_range(0, 127)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_frames(int frames);
    int unsigned n;
    n = frames * frame_extent(cur_rows) * frame_extent(cur_cols);
    for (int unsigned i = 0; i < n; i++)
      push_sample(pick_sample(), $urandom_range(0, 99) < zero_pct);
  endtask

  task automatic push_extremes();
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd1, 1'b1);
  endtask

  function automatic logic [43:0] pick_sigma();
    case ($urandom_range(0, 5))
      0: return 44'd0;
      1: return 44'd32768;
      2: return 44'd65535;
      3: return 44'($urandom_range(0, 255));
      default: return 44'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [43:0] pick_roof();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return ROOF_RESET;
      1: return 44'd0;
      default: return 44'(r >> (20 + $urandom_range(0, 24)));
    endcase
  endfunction

  initial begin : stimulus
    int phase_no;
    int unsigned loop_start;
    mode_t m;
    logic [43:0] rows, cols;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single-row frames of extreme samples through the ones, floor and none modes
    configure(MODE_ONES, 44'd0, ROOF_RESET, 44'd0, 44'd5);
    push_extremes();
    settle();
    write_reg(REG_MODE, 44'(MODE_FLOOR));
    set_idling(1);
    push_extremes();
    settle();
    write_reg(REG_SIGMA, 44'd65535);
    set_idling(2);
    push_extremes();
    settle();
    write_reg(REG_SIGMA, 44'd32768);
    set_idling(3);
    push_extremes();
    settle();
    write_reg(REG_MODE, 44'(MODE_NONE));
    push_extremes();
    settle();

    // smallest frame with an interior, zero roof, widest extents, no interior
    phase_no = 0;
    configure(MODE_ENERGY, 44'd0, ROOF_RESET, 44'd7, 44'd11);
    set_idling(phase_no++);
    queue_frames(1);
    settle();
    configure(MODE_ENERGY, 44'd32768, 44'd0, 44'd9, 44'd13);
    set_idling(phase_no++);
    queue_frames(1);
    settle();
    configure(MODE_FLOOR, pick_sigma(), ROOF_RESET, 44'd1, 44'd1024);
    set_idling(phase_no++);
    queue_frames(1);
    settle();
    configure(MODE_ONES, 44'd0, ROOF_RESET, 44'd2047, 44'd0);
    set_idling(phase_no++);
    queue_frames(1);
    settle();
    configure(MODE_ENERGY, pick_sigma(), pick_roof(), 44'd6, 44'd20);
    set_idling(phase_no++);
    queue_frames(1);
    settle();

    // random frames, mostly windowed energy
    loop_start = samples_queued;
    while (samples_queued - loop_start < 150) begin
      if ($urandom_range(0, 9) < 7) begin
        m = MODE_ENERGY;
        rows = ($urandom_range(0, 9) == 0) ? 44'($urandom_range(0, 6)) :
                                             44'($urandom_range(7, 24));
        cols = ($urandom_range(0, 9) == 0) ? 44'($urandom_range(11, 40)) :
                                             44'($urandom_range(11, 20));
      end else begin
        m = mode_t'($urandom_range(0, 3));
        rows = 44'($urandom_range(1, 8));
        cols = 44'($urandom_range(1, 16));
      end
      configure(m, pick_sigma(), pick_roof(), rows, cols);
      zero_pct = $urandom_range(0, 50);
      set_idling(phase_no++);
      queue_frames($urandom_range(1, 2));
      settle();
    end

    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("windowed_model_weight_gen_tb: PASS");
    end else begin
      $display("windowed_model_weight_gen_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ windowed_model_weight_gen.f @@
+incdir+rtl
rtl/wmwg_pkg.sv
rtl/wmwg_ram.sv
rtl/wmwg_lines.sv
rtl/wmwg_window.sv
rtl/wmwg_weight.sv
rtl/windowed_model_weight_gen.sv
rtl/wmwg_chk.sv
tb/windowed_model_weight_gen_tb.sv
